// File: hdl/iprtl_pkg.sv
// Package for the IPv4 range lookup table: sizes, opcodes, FSM states,
// the table entry layout and the hint update bundle.
// No dependencies; imported by the interfaces, the top level and the hint registers.
package iprtl_pkg;

	localparam int unsigned TABLE_DEPTH = 4096;
	localparam int unsigned HINT_COUNT  = 6;
	localparam int unsigned HINT_MIN_N  = 8;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W       = IDX_W + 1;
	localparam int unsigned SLOT_W      = $clog2(HINT_COUNT + 1);
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned CODE_W      = 24;
	localparam int unsigned OUT_IDX_W   = 12;

	localparam logic [CODE_W-1:0] CODE_MISS = 24'h007A7A;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_BUILD  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUILD,
		ST_SCAN,
		ST_DONE
	} state_t;

	// one table row as stored in the entry memory
	typedef struct packed {
		logic [ADDR_W-1:0] range_start;
		logic [ADDR_W-1:0] range_last;
		logic [CODE_W-1:0] code;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// control from the sequencer to the hint registers
	typedef struct packed {
		logic              clr;
		logic              mark;
		logic              wr;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  idx;
		logic [ADDR_W-1:0] start;
	} hint_upd_t;

endpackage

// File: hdl/iprtl_if.sv
// Valid/ready channel interfaces for lookup requests and results.
// Depends on iprtl_pkg for field widths.
interface iprtl_item_if import iprtl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [ADDR_W-1:0] address;
	logic [ADDR_W-1:0] range_end;
	logic [CODE_W-1:0] entry_code;

	modport source (output valid, opcode, address, range_end, entry_code, input ready);
	modport sink   (input valid, opcode, address, range_end, entry_code, output ready);
endinterface

interface iprtl_result_if import iprtl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [OUT_IDX_W-1:0] match_index;
	logic [CODE_W-1:0]    match_code;
	logic                 status;

	modport source (output valid, found, match_index, match_code, status, input ready);
	modport sink   (input valid, found, match_index, match_code, status, output ready);
endinterface

// File: hdl/ip_range_table_lookup.sv
// IPv4 range lookup table, top level. One transaction is handled at a time.
// Clear, append and a short build go straight to the done state and the output register; a build
// first reads one entry per hint slot; a lookup reads entries from the hinted start until a hit or the
// end of the filled table, and a miss returns CODE_MISS.
// A new transaction is taken as soon as the previous one is in the output register.
// Reset clears the entry count and the hint valid flag; table memory is left as is.
module ip_range_table_lookup import iprtl_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	iprtl_item_if.sink     item,
	iprtl_result_if.source result
);

	state_t state_q, state_d;

	logic              accept;
	op_t               op;
	logic              full;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  step_q;
	logic [CNT_W-1:0]  bidx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  scan_q;

	logic              rd_en;
	logic [CNT_W-1:0]  rd_idx;
	logic              rd_v_s1;
	logic [CNT_W-1:0]  rd_idx_s1;
	logic [SLOT_W-1:0] rd_slot_s1;

	logic              mem_we;
	entry_t            wr_entry;
	logic [ENTRY_W-1:0] rdata;
	entry_t            ent;
	logic              hit;
	logic              miss;
	logic              load_out;

	hint_upd_t         upd;
	logic [CNT_W-1:0]  hint_begin;
	logic              hints_valid;

	logic              res_found_q;
	logic [OUT_IDX_W-1:0] res_idx_q;
	logic [CODE_W-1:0] res_code_q;
	logic              res_status_q;

	logic              out_valid_q;
	logic              out_found_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_status_q;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign op         = op_t'(item.opcode);
	assign full       = (cnt_q == CNT_W'(TABLE_DEPTH));

	// entry memory: one row per range
	assign mem_we   = accept && op == OP_APPEND && !full;
	assign wr_entry = '{range_start: item.address, range_last: item.range_end,
		code: item.entry_code};

	iprtl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_idx[IDX_W-1:0]),
		.rdata(rdata)
	);

	assign ent = entry_t'(rdata);
	assign hit = (state_q == ST_SCAN) && rd_v_s1 &&
		ent.range_start <= addr_q && addr_q <= ent.range_last;

	iprtl_hints u_hints (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.probe      (item.address),
		.begin_idx  (hint_begin),
		.hints_valid(hints_valid)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read issue and hint control
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rd_idx   = scan_q;
		miss     = 1'b0;
		load_out = 1'b0;
		upd      = '{clr: 1'b0, mark: 1'b0, wr: 1'b0, slot: rd_slot_s1, idx: rd_idx_s1,
			start: ent.range_start};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_CLEAR: begin
							upd.clr = 1'b1;
							state_d = ST_DONE;
						end
						OP_APPEND: begin
							state_d = ST_DONE;
						end
						OP_BUILD: begin
							if (cnt_q < CNT_W'(HINT_MIN_N)) begin
								upd.clr = 1'b1;
								state_d = ST_DONE;
							end else begin
								state_d = ST_BUILD;
							end
						end
						OP_LOOKUP: begin
							state_d = ST_SCAN;
						end
					endcase
				end
			end
			ST_BUILD: begin
				rd_idx = bidx_q;
				rd_en  = (slot_q < SLOT_W'(HINT_COUNT));
				upd.wr = rd_v_s1;
				if (!rd_en && !rd_v_s1) begin
					upd.mark = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_SCAN: begin
				rd_en = (scan_q < cnt_q) && !hit;
				miss  = !hit && !rd_en && !rd_v_s1;
				if (hit || miss) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: entry count, read pipeline, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (accept && op == OP_CLEAR) begin
				cnt_q <= '0;
			end else if (mem_we) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers: scan pointers, pending result, output payload
	always_ff @(posedge clk) begin
		rd_idx_s1  <= rd_idx;
		rd_slot_s1 <= slot_q;
		if (accept) begin
			addr_q       <= item.address;
			scan_q       <= hint_begin;
			step_q       <= cnt_q >> 3;
			bidx_q       <= cnt_q - (cnt_q >> 3);
			slot_q       <= '0;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			res_code_q   <= '0;
			res_status_q <= (op == OP_APPEND) && full;
		end
		if (state_q == ST_BUILD && rd_en) begin
			bidx_q <= bidx_q - step_q;
			slot_q <= slot_q + 1'b1;
		end
		if (state_q == ST_SCAN && rd_en) begin
			scan_q <= scan_q + 1'b1;
		end
		if (hit) begin
			res_found_q <= 1'b1;
			res_idx_q   <= rd_idx_s1[OUT_IDX_W-1:0];
			res_code_q  <= ent.code;
		end else if (miss) begin
			res_code_q <= CODE_MISS;
		end
		if (load_out) begin
			out_found_q  <= res_found_q;
			out_idx_q    <= res_idx_q;
			out_code_q   <= res_code_q;
			out_status_q <= res_status_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.found       = out_found_q;
	assign result.match_index = out_idx_q;
	assign result.match_code  = out_code_q;
	assign result.status      = out_status_q;

	// reads returning from memory stay inside the filled part of the table
	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> rd_idx_s1 < cnt_q)
		else $error("entry read beyond entry count");

	// the entry count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count overflow");

	// valid hints exist only for a table large enough to have them
	a_hints_need_entries: assert property (@(posedge clk) disable iff (!arst_n)
		hints_valid |-> cnt_q >= CNT_W'(HINT_MIN_N))
		else $error("hints valid on a small table");

	// the table is written only when a transaction is taken
	a_write_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE)
		else $error("table write outside idle");

	// a new result appears only from the done state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done state");

endmodule

// File: hdl/iprtl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iprtl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/iprtl_hints.sv
// Scan hint registers and the first-hint selection for a lookup address.
// Depends on iprtl_pkg.
module iprtl_hints import iprtl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hint_upd_t         upd,
	input  logic [ADDR_W-1:0] probe,
	output logic [CNT_W-1:0]  begin_idx,
	output logic              hints_valid
);

	logic [CNT_W-1:0]  hint_idx_q   [HINT_COUNT];
	logic [ADDR_W-1:0] hint_start_q [HINT_COUNT];
	logic              valid_q;

	// hold the valid flag: clear wins over a finished build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.clr) begin
			valid_q <= 1'b0;
		end else if (upd.mark) begin
			valid_q <= 1'b1;
		end
	end

	// capture one hint per returned read
	always_ff @(posedge clk) begin
		for (int k = 0; k < HINT_COUNT; k++) begin
			if (upd.wr && upd.slot == SLOT_W'(k)) begin
				hint_idx_q[k]   <= upd.idx;
				hint_start_q[k] <= upd.start;
			end
		end
	end

	// pick the first hint whose start is at or below the address
	always_comb begin
		begin_idx = '0;
		if (valid_q) begin
			for (int k = HINT_COUNT - 1; k >= 0; k--) begin
				if (probe >= hint_start_q[k]) begin
					begin_idx = hint_idx_q[k];
				end
			end
		end
	end

	assign hints_valid = valid_q;

endmodule
